>>> hw/rtl/plp_pkg.sv
`default_nettype none
package plp_pkg;
  localparam int unsigned MaxPoints = 16;
  localparam int unsigned RegCount = 7;
  localparam int unsigned AddrW = 5;

  localparam logic [2:0] RegWeight = 3'd0;
  localparam logic [2:0] RegCutoff = 3'd1;
  localparam logic [2:0] RegSign = 3'd2;
  localparam logic [2:0] RegNpts = 3'd3;
  localparam logic [2:0] RegSeep = 3'd4;
  localparam logic [2:0] RegFixVal = 3'd5;
  localparam logic [2:0] RegFixGiv = 3'd6;

  localparam logic [1:0] ActLeave = 2'd0;
  localparam logic [1:0] ActFix = 2'd1;
  localparam logic [1:0] ActFree = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_RD0, S_RD1, S_RDW, S_DIV, S_MUL1, S_ML1, S_MH1, S_HGT,
    S_MUL2, S_ML2, S_MH2, S_PRD, S_FIN, S_OUT
  } plp_state_t;

  typedef struct packed {
    logic load;
    logic srch_start;
    logic srch_step;
    logic rd_lo;
    logic rd_hi;
    logic div_start;
    logic div_step;
    logic mul1;
    logic mul_lo;
    logic mul_hi;
    logic hgt;
    logic mul2;
    logic prd;
    logic fin;
    logic out_set;
  } plp_cmd_t;

  typedef struct packed {
    logic srch_done;
    logic div_done;
  } plp_sts_t;

  // (a*b)>>16 on magnitudes, saturated to 2^60
  function automatic logic signed [63:0] mag_fix(input logic neg, input logic [127:0] prod);
    logic [111:0] r;
    logic [63:0] m;
    begin
      r = prod[127:16];
      if (r > 112'(64'h1000_0000_0000_0000)) m = 64'h1000_0000_0000_0000;
      else m = r[63:0];
      mag_fix = neg ? -$signed(m) : $signed(m);
    end
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/plp_ram.sv
`default_nettype none
module plp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/plp_ctrl.sv
`default_nettype none
module plp_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic in_eval,
  input  wire logic out_fire,
  input  wire plp_pkg::plp_sts_t sts,
  output plp_pkg::plp_cmd_t cmd,
  output logic busy
);
  import plp_pkg::*;
  plp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // sequence one request: a write goes straight to output, an evaluate runs through search, divide, two split products
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = in_eval ? S_SRCH : S_OUT;
      S_SRCH: if (sts.srch_done) state_next = S_RD0;
      S_RD0: state_next = S_RD1;
      S_RD1: state_next = S_RDW;
      S_RDW: state_next = S_DIV;
      S_DIV: if (sts.div_done) state_next = S_MUL1;
      S_MUL1: state_next = S_ML1;
      S_ML1: state_next = S_MH1;
      S_MH1: state_next = S_HGT;
      S_HGT: state_next = S_MUL2;
      S_MUL2: state_next = S_ML2;
      S_ML2: state_next = S_MH2;
      S_MH2: state_next = S_PRD;
      S_PRD: state_next = S_FIN;
      S_FIN: state_next = S_OUT;
      S_OUT: if (out_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    unique case (state) inside
      S_IDLE: begin
        cmd.load = in_fire;
        cmd.srch_start = in_fire;
        cmd.out_set = in_fire && !in_eval;
      end
      S_SRCH: cmd.srch_step = 1'b1;
      S_RD0: cmd.rd_lo = 1'b1;
      S_RD1: cmd.rd_hi = 1'b1;
      S_RDW: cmd.div_start = 1'b1;
      S_DIV: cmd.div_step = 1'b1;
      S_MUL1: cmd.mul1 = 1'b1;
      S_ML1, S_ML2: cmd.mul_lo = 1'b1;
      S_MH1, S_MH2: cmd.mul_hi = 1'b1;
      S_HGT: cmd.hgt = 1'b1;
      S_MUL2: cmd.mul2 = 1'b1;
      S_PRD: cmd.prd = 1'b1;
      S_FIN: begin
        cmd.fin = 1'b1;
        cmd.out_set = 1'b1;
      end
      S_OUT: ;
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

>>> hw/rtl/plp_dp.sv
`default_nettype none
module plp_dp #(
  parameter int unsigned MaxPts = plp_pkg::MaxPoints
) (
  input  wire logic clk,
  input  wire plp_pkg::plp_cmd_t cmd,
  output plp_pkg::plp_sts_t sts,
  input  wire logic in_eval,
  input  wire logic [3:0] in_index,
  input  wire logic signed [31:0] in_x,
  input  wire logic signed [31:0] in_v,
  input  wire logic [30:0] weight,
  input  wire logic signed [31:0] cutoff,
  input  wire logic sign_neg,
  input  wire logic [4:0] npts,
  input  wire logic seep,
  input  wire logic fix_val,
  input  wire logic fix_giv,
  output logic signed [47:0] pressure,
  output logic write_value,
  output logic [1:0] fixity_action
);
  import plp_pkg::*;
  localparam int unsigned IW = (MaxPts > 1) ? $clog2(MaxPts) : 1;
  localparam int unsigned CW = $clog2(MaxPts + 1);

  logic [CW-1:0] n_eff, i_cnt, k;
  logic [IW-1:0] raddr;
  logic [31:0] hx_q, vy_q;
  logic signed [31:0] x, v, x0, y0;
  logic sfound, we;
  logic rd_ph;

  // clamp point count
  always_comb begin
    if (npts < 5'd2) n_eff = CW'(2);
    else if (32'(npts) > 32'(MaxPts)) n_eff = CW'(MaxPts);
    else n_eff = CW'(npts);
  end

  assign we = cmd.load && !in_eval && (32'(in_index) < 32'(MaxPts));

  always_comb begin
    if (cmd.rd_lo) raddr = k[IW-1:0];
    else if (cmd.rd_hi) raddr = IW'(k + CW'(1));
    else raddr = i_cnt[IW-1:0];
  end

  plp_ram #(.Width(32), .Depth(MaxPts)) u_hx (
    .clk(clk), .we(we), .waddr(IW'(in_index)), .wdata(in_x),
    .raddr(raddr), .rdata(hx_q));
  plp_ram #(.Width(32), .Depth(MaxPts)) u_vy (
    .clk(clk), .we(we), .waddr(IW'(in_index)), .wdata(in_v),
    .raddr(raddr), .rdata(vy_q));

  // search: address i issued, data arrives in the next cycle
  logic [CW-1:0] i_prev;
  logic prev_ok;
  assign sts.srch_done = sfound || (prev_ok && i_prev == n_eff - CW'(1) &&
                                    !($signed(hx_q) >= x));
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= in_x;
      v <= in_v;
    end
    if (cmd.srch_start) begin
      i_cnt <= '0;
      prev_ok <= 1'b0;
      sfound <= 1'b0;
      k <= n_eff - CW'(2);
    end else if (cmd.srch_step && !sts.srch_done) begin
      if (prev_ok && $signed(hx_q) >= x) begin
        sfound <= 1'b1;
        k <= (i_prev == '0) ? '0 : i_prev - CW'(1);
      end
      prev_ok <= 1'b1;
      i_prev <= i_cnt;
      if (i_cnt != n_eff - CW'(1)) i_cnt <= i_cnt + CW'(1);
    end
    rd_ph <= cmd.rd_lo;
    if (rd_ph) begin
      x0 <= hx_q;
      y0 <= vy_q;
    end
  end

  // restoring divider: |dy|<<16 / |dx|, one bit a cycle
  logic signed [32:0] dx, dy;
  logic [32:0] adx;
  logic [48:0] dquo, drem_src;
  logic [33:0] drem;
  logic [5:0] dcnt;
  logic dneg, dzero;
  logic [33:0] trial;
  assign dx = 33'($signed(hx_q)) - 33'(x0);
  assign dy = 33'($signed(vy_q)) - 33'(y0);
  assign trial = {drem[32:0], drem_src[48]} - {1'b0, adx};
  assign sts.div_done = (dcnt == 6'd0);
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      adx <= dx[32] ? 33'(-dx) : 33'(dx);
      drem_src <= {(dy[32] ? 33'(-dy) : 33'(dy)), 16'd0};
      drem <= '0;
      dquo <= '0;
      dcnt <= 6'd49;
      dneg <= dx[32] ^ dy[32];
      dzero <= (dx == 33'sd0);
    end else if (cmd.div_step && dcnt != 6'd0) begin
      if (!trial[33]) begin
        drem <= trial;
        dquo <= {dquo[47:0], 1'b1};
      end else begin
        drem <= {drem[32:0], drem_src[48]};
        dquo <= {dquo[47:0], 1'b0};
      end
      drem_src <= {drem_src[47:0], 1'b0};
      dcnt <= dcnt - 6'd1;
    end
  end

  // products: one 32x32 multiplier, wide operand low half then high half
  logic [63:0] ma, mprod;
  logic [31:0] mb, msel;
  logic [95:0] acc;
  logic mneg;
  logic signed [63:0] distance, prod2, p_sat, cut;
  logic signed [32:0] xd;
  assign xd = 33'(x) - 33'(x0);
  assign msel = cmd.mul_hi ? ma[63:32] : ma[31:0];
  assign mprod = 64'(msel) * 64'(mb);
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      ma <= dzero ? 64'd0 : 64'(dquo);
      mb <= xd[32] ? 32'(-xd) : xd[31:0];
      mneg <= !dzero && dquo != '0 && (dneg != xd[32]) && xd != '0;
    end else if (cmd.mul2) begin
      ma <= distance[63] ? -distance : distance;
      mb <= {1'b0, weight};
      mneg <= distance[63];
    end
    if (cmd.mul_lo) acc <= 96'(mprod);
    else if (cmd.mul_hi) acc <= acc + {mprod, 32'd0};
    if (cmd.hgt) distance <= mag_fix(mneg, 128'(acc)) + 64'(y0) - 64'(v);
    if (cmd.prd) prod2 <= mag_fix(mneg, 128'(acc));
  end

  // saturate, apply rule
  logic signed [63:0] p_raw;
  always_comb begin
    p_raw = sign_neg ? prod2 : -prod2;
    if (p_raw > 64'sd140737488355327) p_sat = 64'sd140737488355327;
    else if (p_raw < -64'sd140737488355328) p_sat = -64'sd140737488355328;
    else p_sat = p_raw;
    cut = sign_neg ? -64'(cutoff) : 64'(cutoff);
  end
  always_ff @(posedge clk) begin
    if (cmd.out_set && !cmd.fin) begin
      pressure <= '0;
      write_value <= 1'b0;
      fixity_action <= ActLeave;
    end else if (cmd.fin) begin
      if (seep) begin
        if (p_sat < cut) begin
          pressure <= p_sat[47:0];
          write_value <= 1'b1;
          fixity_action <= fix_val ? ActFix : ActLeave;
        end else begin
          pressure <= '0;
          write_value <= 1'b0;
          fixity_action <= fix_giv ? ActFree : ActLeave;
        end
      end else begin
        pressure <= (p_sat > cut) ? cut[47:0] : p_sat[47:0];
        write_value <= 1'b1;
        fixity_action <= fix_val ? ActFix : (fix_giv ? ActFree : ActLeave);
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/phreatic_line_pressure_unit.sv
// Channel | Dir | Fields (tdata low bit up)
// s_axis  | in  | tuser: func; tdata: point_index[3:0], coord_horizontal[35:4],
//         |     |   coord_vertical[67:36], zero pad to 72
// m_axis  | out | tdata: pressure[47:0], write_value[48], fixity_action[50:49],
//         |     |   zero pad to 56
// apb     | cfg | seven 32-bit registers at 4*i
// A write's result is valid in the cycle after acceptance; an evaluate's after a
// search over n points (one RAM read a cycle), the read states RD0, RD1 and RDW,
// a restoring divider and two split 32x32 products.
// The next request is taken in the cycle after the result is taken, so a new
// request is never accepted before the last result has left.
// Reset is synchronous active high; one request at a time, s_tready low until taken.
`default_nettype none
module phreatic_line_pressure_unit #(
  parameter int unsigned MAX_POINTS = plp_pkg::MaxPoints
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [71:0] s_tdata,
  input  wire logic s_tuser,
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [55:0] m_tdata,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [plp_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import plp_pkg::*;
  logic [30:0] weight;
  logic signed [31:0] cutoff;
  logic sign_neg, seep, fix_val, fix_giv, busy, in_fire, out_fire;
  logic [4:0] npts;
  logic signed [47:0] pressure;
  logic write_value;
  logic [1:0] fixity_action;
  plp_cmd_t cmd;
  plp_sts_t sts;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= 31'd655360000;
      cutoff <= '0;
      sign_neg <= 1'b1;
      npts <= 5'd2;
      seep <= 1'b0;
      fix_val <= 1'b0;
      fix_giv <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        RegWeight: weight <= pwdata[30:0];
        RegCutoff: cutoff <= pwdata;
        RegSign: sign_neg <= pwdata[0];
        RegNpts: npts <= pwdata[4:0];
        RegSeep: seep <= pwdata[0];
        RegFixVal: fix_val <= pwdata[0];
        RegFixGiv: fix_giv <= pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (ridx)
      RegWeight: prdata = {1'b0, weight};
      RegCutoff: prdata = cutoff;
      RegSign: prdata = {31'd0, sign_neg};
      RegNpts: prdata = {27'd0, npts};
      RegSeep: prdata = {31'd0, seep};
      RegFixVal: prdata = {31'd0, fix_val};
      RegFixGiv: prdata = {31'd0, fix_giv};
      default: prdata = '0;
    endcase
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.out_set) m_tvalid <= 1'b1;
    else if (out_fire) m_tvalid <= 1'b0;
  end
  assign s_tready = !busy;
  assign in_fire = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign m_tdata = {5'd0, fixity_action, write_value, pressure};

  plp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_eval(s_tuser),
    .out_fire(out_fire), .sts(sts), .cmd(cmd), .busy(busy));

  plp_dp #(.MaxPts(MAX_POINTS)) u_dp (
    .clk(clk), .cmd(cmd), .sts(sts), .in_eval(s_tuser), .in_index(s_tdata[3:0]),
    .in_x(s_tdata[35:4]), .in_v(s_tdata[67:36]), .weight(weight), .cutoff(cutoff),
    .sign_neg(sign_neg), .npts(npts), .seep(seep), .fix_val(fix_val),
    .fix_giv(fix_giv), .pressure(pressure), .write_value(write_value),
    .fixity_action(fixity_action));

  // no new request while a result is pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("accept while result pending");
  // write requests always answer with zero
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !s_tuser) |=> (m_tvalid && m_tdata == 56'd0))
    else $error("write result not zero");
  // fixity code stays in range
  a_act_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (fixity_action != 2'd3)) else $error("bad fixity code");
endmodule
`default_nettype wire

>>> sim/tb_phreatic_line_pressure_unit.sv
`timescale 1ns / 1ps
module tb_phreatic_line_pressure_unit;
  import plp_pkg::*;

  typedef struct {
    logic func;
    logic [3:0] slot;
    logic signed [31:0] xh;
    logic signed [31:0] yv;
  } node_req_t;

  typedef struct {
    logic signed [47:0] pressure;
    logic write_value;
    logic [1:0] fixity;
  } pore_res_t;

  localparam int StallLimit = 5000;
  localparam longint SatMag = 64'sh1000_0000_0000_0000;
  localparam longint P48Max = 64'sd140737488355327;
  localparam longint P48Min = -64'sd140737488355328;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [71:0] s_tdata = '0;  // point_index, coord_horizontal, coord_vertical, pad
  logic s_tuser = 1'b0;       // func
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [55:0] m_tdata;       // pressure, write_value, fixity_action, pad
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  phreatic_line_pressure_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local copy of the line and settings
  logic signed [31:0] line_x [MaxPoints];
  logic signed [31:0] line_y [MaxPoints];
  logic [30:0] weight_q = 31'd655360000;
  logic signed [31:0] cutoff_q = '0;
  logic sign_neg = 1'b1;
  logic [4:0] npts = 5'd2;
  logic seep_on = 1'b0;
  logic fix_val = 1'b0;
  logic fix_giv = 1'b0;

  node_req_t pending_reqs[$];
  pore_res_t expected_res[$];
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_left = 0;
  int errors = 0;
  int stall_cnt = 0;
  bit s_took = 1'b0;

  // (a*b)>>16 on magnitudes, truncated, saturated to 2^60
  function automatic longint mul_q16(longint a, longint b);
    logic [63:0] ua, ub;
    logic [127:0] pr;
    logic [111:0] r;
    longint m;
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    pr = {64'd0, ua} * {64'd0, ub};
    r = pr[127:16];
    m = (r > 112'(SatMag)) ? SatMag : longint'(r[63:0]);
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic pore_res_t pore_pressure(node_req_t rq);
    pore_res_t res;
    int n, k;
    bit found;
    longint x0, x1, y0, y1, dx, slope, height, p, cut;
    res.pressure = '0;
    res.write_value = 1'b0;
    res.fixity = ActLeave;
    if (!rq.func) begin
      line_x[rq.slot] = rq.xh;
      line_y[rq.slot] = rq.yv;
      return res;
    end
    n = npts;
    if (n < 2) n = 2;
    if (n > MaxPoints) n = MaxPoints;
    k = n - 2;
    found = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && line_x[i] >= rq.xh) begin
        k = (i == 0) ? 0 : i - 1;
        found = 1;
      end
    end
    x0 = line_x[k];
    x1 = line_x[k+1];
    y0 = line_y[k];
    y1 = line_y[k+1];
    dx = x1 - x0;
    slope = (dx == 0) ? 0 : ((y1 - y0) * 65536) / dx;
    height = mul_q16(slope, longint'(rq.xh) - x0) + y0;
    p = mul_q16(longint'(weight_q), height - longint'(rq.yv));
    if (!sign_neg) p = -p;
    if (p > P48Max) p = P48Max;
    if (p < P48Min) p = P48Min;
    cut = sign_neg ? -longint'(cutoff_q) : longint'(cutoff_q);
    if (seep_on) begin
      if (p < cut) begin
        res.write_value = 1'b1;
        res.fixity = fix_val ? ActFix : ActLeave;
      end else begin
        p = 0;
        res.fixity = fix_giv ? ActFree : ActLeave;
      end
    end else begin
      res.write_value = 1'b1;
      res.fixity = fix_val ? ActFix : (fix_giv ? ActFree : ActLeave);
      if (p > cut) p = cut;
    end
    res.pressure = p[47:0];
    return res;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  // monitor: accept requests, predict, check results
  always @(posedge clk) begin
    pore_res_t e;
    s_took = !rst && s_tvalid && s_tready;
    if (s_took) begin
      expected_res.push_back(pore_pressure(pending_reqs.pop_front()));
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_res.size() == 0) begin
        report("unexpected result", 64'(m_tdata), 64'd0);
      end else begin
        e = expected_res.pop_front();
        if (m_tdata[47:0] !== e.pressure) report("pressure", 64'(m_tdata[47:0]), 64'(e.pressure));
        if (m_tdata[48] !== e.write_value) report("write_value", 64'(m_tdata[48]), 64'(e.write_value));
        if (m_tdata[50:49] !== e.fixity) report("fixity_action", 64'(m_tdata[50:49]), 64'(e.fixity));
      end
    end
    if (rst || s_took || (m_tvalid && m_tready) || psel) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // driver: offer the oldest pending request, hold it until taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_took) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tuser <= pending_reqs[0].func;
        s_tdata <= {4'd0, pending_reqs[0].yv, pending_reqs[0].xh, pending_reqs[0].slot};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus the long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegWeight: weight_q = val[30:0];
      RegCutoff: cutoff_q = val;
      RegSign:   sign_neg = val[0];
      RegNpts:   npts = val[4:0];
      RegSeep:   seep_on = val[0];
      RegFixVal: fix_val = val[0];
      RegFixGiv: fix_giv = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] w, logic [31:0] c, logic sg, logic [4:0] n,
                            logic sp, logic fv, logic fg);
    reg_write(RegWeight, w);
    reg_write(RegCutoff, c);
    reg_write(RegSign, 32'(sg));
    reg_write(RegNpts, 32'(n));
    reg_write(RegSeep, 32'(sp));
    reg_write(RegFixVal, 32'(fv));
    reg_write(RegFixGiv, 32'(fg));
  endtask

  task automatic push_req(logic f, logic [3:0] s, logic [31:0] x, logic [31:0] v);
    node_req_t rq;
    rq.func = f;
    rq.slot = s;
    rq.xh = x;
    rq.yv = v;
    pending_reqs.push_back(rq);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
      default: return 32'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
    endcase
  endfunction

  // load a sorted line into all slots, with an occasional zero-width segment
  task automatic load_line(bit wide);
    logic [31:0] xs;
    xs = -32'($urandom_range(0, 32'h3000_0000)) - 32'h0800_0000;
    for (int i = 0; i < MaxPoints; i++) begin
      push_req(1'b0, 4'(i), xs, wide ? $urandom() : rand_coord());
      if ($urandom_range(0, 5) != 0) xs = xs + $urandom_range(1, 32'h0100_0000);
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_res.size() > 0 || s_tvalid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(int cnt);
    load_line($urandom_range(0, 3) == 0);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 9) < 2)
        push_req(1'b0, 4'($urandom()), rand_coord(), rand_coord());
      else
        push_req(1'b1, 4'($urandom()), rand_coord(), rand_coord());
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    snd_idle_pct = 26;
    rcv_idle_pct = 71;

    // directed: fill the line, zero-width segment between slots 3 and 4
    for (int i = 0; i < MaxPoints; i++) begin
      push_req(1'b0, 4'(i), 32'(i * 32'h0001_0000) - (i > 3 ? 32'h0001_0000 : 0),
               32'(i * 32'h0000_8000));
    end
    push_req(1'b1, 4'hf, 32'h8000_0000, 32'h8000_0000);  // before the first point
    push_req(1'b1, 4'h0, 32'h7fff_ffff, 32'h7fff_ffff);  // past the last point
    push_req(1'b1, 4'h0, 32'h0001_0000, 32'h0000_0000);  // on a point
    push_req(1'b1, 4'h0, 32'h0000_8000, 32'hffff_0000);  // inside a segment
    drain();
    set_config(32'h7fff_ffff, 32'h8000_0000, 1'b0, 5'd16, 1'b1, 1'b1, 1'b1);
    push_req(1'b1, 4'h0, 32'h0003_0000, 32'h8000_0000);  // at the x of the zero-width segment
    push_req(1'b1, 4'h0, 32'h7fff_ffff, 32'h8000_0000);
    push_req(1'b1, 4'h0, 32'h8000_0000, 32'h7fff_ffff);
    push_req(1'b0, 4'hf, 32'h7fff_ffff, 32'hffff_ffff);
    push_req(1'b1, 4'h0, 32'h7000_0000, 32'h0000_0000);
    drain();

    random_phase(70);
    set_config(32'h0000_0000, 32'h7fff_ffff, 1'b1, 5'd0, 1'b0, 1'b0, 1'b1);
    random_phase(70);

    snd_idle_pct = 71;
    rcv_idle_pct = 26;
    set_config($urandom(), $urandom(), 1'($urandom_range(0, 1)), 5'd31, 1'b1, 1'b0, 1'b0);
    random_phase(70);
    set_config($urandom(), $urandom(), 1'($urandom_range(0, 1)), 5'($urandom_range(2, 16)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
    random_phase(70);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_config(32'h0010_0000, $urandom(), 1'b1, 5'd1, 1'b1, 1'b0, 1'b1);
    @(posedge clk);
    hold_left = 400;
    random_phase(70);
    set_config($urandom(), $urandom(), 1'($urandom_range(0, 1)), 5'($urandom_range(2, 16)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
    random_phase(70);
    set_config(32'd655360000, 32'h0000_0000, 1'b1, 5'd2, 1'b0, 1'b1, 1'b0);
    random_phase(40);

    repeat (100) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> sim.f
hw/rtl/plp_pkg.sv
hw/rtl/plp_ram.sv
hw/rtl/plp_ctrl.sv
hw/rtl/plp_dp.sv
hw/rtl/phreatic_line_pressure_unit.sv
sim/tb_phreatic_line_pressure_unit.sv
